// ===== hw/rtl/rcd_pkg.sv =====
// Shared types, constants and lookup functions for the character reference decoder.
package rcd_pkg;

   localparam int NAME_MAX_DEF = 16;
   localparam int MAX_RESULTS  = 20;
   localparam int NUM_NAMES    = 34;
   localparam int NAME_TXT_LEN = 14;
   localparam int NLEN_W       = 6;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

   localparam logic [20:0] CP_SAT  = 21'h110000;
   localparam logic [20:0] CP_MAX  = 21'h10FFFF;
   localparam logic [20:0] CP_REPL = 21'h00FFFD;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LX   = 8'h78;
   localparam logic [7:0] CH_UX   = 8'h58;
   localparam logic [7:0] CH_NUL  = 8'h00;

   localparam logic [2:0] W_NONE    = 3'd0;
   localparam logic [2:0] W_SEMI    = 3'd1;
   localparam logic [2:0] W_UNKNOWN = 3'd2;
   localparam logic [2:0] W_NODIG   = 3'd3;
   localparam logic [2:0] W_NULL    = 3'd4;

   typedef enum logic [2:0] {
      M_NORMAL, M_AMP, M_HASH, M_HEXL, M_HEXU, M_DIGITS, M_NAME
   } mode_type;

   typedef enum logic [2:0] {
      SK_NONE, SK_RAW, SK_CP, SK_LIT, SK_NODIG
   } seg_kind_type;

   typedef enum logic {
      ST_IDLE, ST_EMIT
   } seq_state_type;

   // classified text byte, as passed from the front to the back
   typedef struct packed {
      logic [7:0] in_byte;
      logic       flush;
      logic       alnum;
      logic       dec_ok;
      logic       hex_ok;
      logic [3:0] dval;
   } item_type;

   // one run of output bytes
   typedef struct packed {
      seg_kind_type      kind;
      logic [20:0]       data;
      logic [2:0]        warn;
      logic [NLEN_W-1:0] len;
   } seg_type;

   localparam logic [8*NAME_TXT_LEN-1:0] NAME_TXT [NUM_NAMES] = '{
      "amp", "apos", "bull", "cent", "copy", "deg", "divide", "euro", "gt",
      "hellip", "laquo", "ldquo", "lsaquo", "lsquo", "lt", "mdash", "micro",
      "middot", "nbsp", "ndash", "para", "plusmn", "pound", "quot", "raquo",
      "rdquo", "reg", "rsaquo", "rsquo", "sect", "times", "trade", "yen",
      "ZeroWidthSpace"
   };

   localparam logic [NLEN_W-1:0] NAME_LEN [NUM_NAMES] = '{
      6'd3, 6'd4, 6'd4, 6'd4, 6'd4, 6'd3, 6'd6, 6'd4, 6'd2,
      6'd6, 6'd5, 6'd5, 6'd6, 6'd5, 6'd2, 6'd5, 6'd5,
      6'd6, 6'd4, 6'd5, 6'd4, 6'd6, 6'd5, 6'd4, 6'd5,
      6'd5, 6'd3, 6'd6, 6'd5, 6'd4, 6'd5, 6'd5, 6'd3,
      6'd14
   };

   localparam logic [15:0] NAME_CP [NUM_NAMES] = '{
      16'h0026, 16'h0027, 16'h2022, 16'h00A2, 16'h00A9, 16'h00B0, 16'h00F7,
      16'h20AC, 16'h003E, 16'h2026, 16'h00AB, 16'h201C, 16'h2039, 16'h2018,
      16'h003C, 16'h2014, 16'h00B5, 16'h00B7, 16'h00A0, 16'h2013, 16'h00B6,
      16'h00B1, 16'h00A3, 16'h0022, 16'h00BB, 16'h201D, 16'h00AE, 16'h203A,
      16'h2019, 16'h00A7, 16'h00D7, 16'h2122, 16'h00A5, 16'h200B
   };

   // character k of name i, zero past its end
   function automatic logic [7:0] name_char(input int i, input logic [NLEN_W-1:0] k);
      logic [7:0] ch;
      ch = 8'h00;
      if (k < NAME_LEN[i]) begin
         ch = NAME_TXT[i][8*(int'(NAME_LEN[i]) - 1 - int'(k)) +: 8];
      end
      return ch;
   endfunction

   // C1 control range remap; zero keeps the value
   function automatic logic [15:0] remap_c1(input logic [4:0] idx);
      logic [15:0] r;
      case (idx)
         5'd0:  r = 16'h20AC;
         5'd2:  r = 16'h201A;
         5'd3:  r = 16'h0192;
         5'd4:  r = 16'h201E;
         5'd5:  r = 16'h2026;
         5'd6:  r = 16'h2020;
         5'd7:  r = 16'h2021;
         5'd8:  r = 16'h02C6;
         5'd9:  r = 16'h2030;
         5'd10: r = 16'h0160;
         5'd11: r = 16'h2039;
         5'd12: r = 16'h0152;
         5'd14: r = 16'h017D;
         5'd17: r = 16'h2018;
         5'd18: r = 16'h2019;
         5'd19: r = 16'h201C;
         5'd20: r = 16'h201D;
         5'd21: r = 16'h2022;
         5'd22: r = 16'h2013;
         5'd23: r = 16'h2014;
         5'd24: r = 16'h02DC;
         5'd25: r = 16'h2122;
         5'd26: r = 16'h0161;
         5'd27: r = 16'h203A;
         5'd28: r = 16'h0153;
         5'd30: r = 16'h017E;
         5'd31: r = 16'h0178;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

   function automatic logic cp_bad(input logic [20:0] cp);
      return (cp == 21'd0) || (cp > CP_MAX) || (cp >= 21'h00D800 && cp <= 21'h00DFFF);
   endfunction

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] n;
      if (cp_bad(cp)) n = 3'd3;
      else if (cp <= 21'h7F) n = 3'd1;
      else if (cp <= 21'h7FF) n = 3'd2;
      else if (cp <= 21'hFFFF) n = 3'd3;
      else n = 3'd4;
      return n;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
      logic [20:0] v;
      logic [2:0]  n;
      logic [7:0]  b;
      v = cp_bad(cp) ? CP_REPL : cp;
      n = utf8_len(v);
      b = 8'h00;
      case (n)
         3'd1: b = v[7:0];
         3'd2: b = (k == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
         3'd3: begin
            case (k)
               2'd0: b = {4'b1110, v[15:12]};
               2'd1: b = {2'b10, v[11:6]};
               default: b = {2'b10, v[5:0]};
            endcase
         end
         default: begin
            case (k)
               2'd0: b = {5'b11110, v[20:18]};
               2'd1: b = {2'b10, v[17:12]};
               2'd2: b = {2'b10, v[11:6]};
               default: b = {2'b10, v[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

   function automatic logic [NLEN_W:0] seg_len(input seg_type s);
      logic [NLEN_W:0] n;
      case (s.kind)
         SK_RAW:   n = (NLEN_W+1)'(1);
         SK_CP:    n = (NLEN_W+1)'(utf8_len(s.data));
         SK_LIT:   n = (NLEN_W+1)'(s.len) + (NLEN_W+1)'(1);
         SK_NODIG: n = (s.data[1:0] != 2'd0) ? (NLEN_W+1)'(3) : (NLEN_W+1)'(2);
         default:  n = '0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/html_char_reference_decoder.sv =====
// Top level of the HTML character reference decoder (text bytes in, UTF-8 bytes out).
//
//   channel  direction  handshake      payload
//   req      in         push / full    req_in_byte, req_flush
//   rsp      out        pop / empty    rsp_out_byte, rsp_last, rsp_warn_code
//
// An item waits in the two-entry front queue, is decoded when the idle byte
// sequencer takes it, and its result bytes then leave the sequencer one at a
// time; the sequencer takes no new item until the last byte of its run is out.
// The sequencer and its single output register set the rate.
// Reset is synchronous and returns the decoder to plain text mode.
// A full output register stalls the sequencer; the front queue keeps taking items
// until it holds two.
module html_char_reference_decoder #(
   parameter int NAME_MAX = rcd_pkg::NAME_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_flush,
   input  logic       req_push,
   output logic       req_full,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_warn_code,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   logic              item_valid;
   logic              item_take;
   rcd_pkg::item_type item;

   rcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_in_byte (req_in_byte),
      .req_flush   (req_flush),
      .req_push    (req_push),
      .req_full    (req_full),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take)
   );

   rcd_back #(
      .NAME_MAX (NAME_MAX)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_warn_code (rsp_warn_code),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule

// ===== hw/rtl/rcd_front.sv =====
// Front end: classifies incoming text bytes and queues them for the decoder.
module rcd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_in_byte,
   input  logic              req_flush,
   input  logic              req_push,
   output logic              req_full,
   output logic              item_valid,
   output rcd_pkg::item_type item,
   input  logic              item_take
);

   rcd_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   rcd_pkg::item_type cls;
   logic              do_wr, do_rd;
   logic [7:0]        c;

   always_comb begin
      c = req_in_byte;
      cls.in_byte = c;
      cls.flush   = req_flush;
      cls.dec_ok  = (c >= 8'h30 && c <= 8'h39);
      cls.alnum   = cls.dec_ok || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
      cls.hex_ok  = cls.dec_ok || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
      if (cls.dec_ok) cls.dval = 4'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) cls.dval = 4'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) cls.dval = 4'(c - 8'h37);
      else cls.dval = 4'd0;
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign do_wr      = req_push && !req_full;
   assign do_rd      = item_take && item_valid;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");
   assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("write did not raise count");

endmodule

// ===== hw/rtl/rcd_back.sv =====
// Back end: reference decoding state and UTF-8 byte sequencer with output register.
module rcd_back #(
   parameter int NAME_MAX = rcd_pkg::NAME_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  rcd_pkg::item_type item,
   output logic              item_take,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic [2:0]        rsp_warn_code,
   output logic              rsp_empty,
   input  logic              rsp_pop
);

   localparam int IDX_W = $clog2(NAME_MAX);
   localparam int NW    = rcd_pkg::NLEN_W;
   localparam int CW    = rcd_pkg::CNT_W;

   rcd_pkg::mode_type      mode_ff, mode_in;
   logic                   hex_ff, hex_in;
   logic [20:0]            code_ff, code_in;
   logic [NW-1:0]          nlen_ff, nlen_in;
   logic [7:0]             name_store [NAME_MAX];
   logic [rcd_pkg::NUM_NAMES-1:0] match_ff, match_in;
   logic                   nwr;
   logic [IDX_W-1:0]       nwr_idx;

   rcd_pkg::seq_state_type st_ff, st_in;
   rcd_pkg::seg_type       sa_ff, sb_ff, sa_in, sb_in, nseg;
   logic [NW:0]            la_ff, la_in;
   logic [CW-1:0]          tot_ff, tot_in, k_ff, k_in;

   logic                   oval_ff, oval_in;
   logic [7:0]             obyte_ff;
   logic                   olast_ff;
   logic [2:0]             owarn_ff;

   logic                   start, emit, slot_free, known, replay, do_norm;
   logic [20:0]            named_cp, num_cp, acc;
   logic [24:0]            acc_w;
   logic [NW:0]            lb, sum_len, kk, kb;
   logic [7:0]             c, ebyte, lit_ch;
   logic [2:0]             ewarn;
   logic                   elast;
   rcd_pkg::seg_type       cur;
   logic [15:0]            rm;

   assign c = item.in_byte;

   // name match and numeric value selection
   always_comb begin
      named_cp = '0;
      for (int i = 0; i < rcd_pkg::NUM_NAMES; i++) begin
         if (match_ff[i] && rcd_pkg::NAME_LEN[i] == nlen_ff) begin
            named_cp = named_cp | 21'(rcd_pkg::NAME_CP[i]);
         end
      end
      known = (named_cp != '0);
      rm = rcd_pkg::remap_c1(code_ff[4:0]);
      num_cp = (code_ff >= 21'h80 && code_ff <= 21'h9F && rm != 16'h0) ? 21'(rm) : code_ff;
      acc_w = hex_ff ? ({code_ff, 4'b0} + 25'(item.dval))
                     : (({4'b0, code_ff} << 3) + ({4'b0, code_ff} << 1) + 25'(item.dval));
      acc   = (acc_w > 25'(rcd_pkg::CP_SAT)) ? rcd_pkg::CP_SAT : acc_w[20:0];
   end

   // decode one item into up to two output runs and the next state
   always_comb begin
      mode_in  = mode_ff;
      hex_in   = hex_ff;
      code_in  = code_ff;
      nlen_in  = nlen_ff;
      match_in = match_ff;
      nwr      = 1'b0;
      nwr_idx  = nlen_ff[IDX_W-1:0];
      sa_in    = '{kind: rcd_pkg::SK_NONE, data: '0, warn: rcd_pkg::W_NONE, len: nlen_ff};
      sb_in    = sa_in;
      nseg     = sa_in;
      replay   = 1'b0;
      do_norm  = 1'b0;
      if (item.flush) begin
         case (mode_ff)
            rcd_pkg::M_AMP: begin
               sa_in.kind = rcd_pkg::SK_RAW;
               sa_in.data = 21'(rcd_pkg::CH_AMP);
            end
            rcd_pkg::M_HASH, rcd_pkg::M_HEXL, rcd_pkg::M_HEXU: begin
               sa_in.kind = rcd_pkg::SK_NODIG;
               sa_in.warn = rcd_pkg::W_NODIG;
               sa_in.data = (mode_ff == rcd_pkg::M_HEXL) ? 21'd1 :
                            (mode_ff == rcd_pkg::M_HEXU) ? 21'd2 : 21'd0;
            end
            rcd_pkg::M_DIGITS: begin
               sa_in.kind = rcd_pkg::SK_CP;
               sa_in.data = num_cp;
               sa_in.warn = rcd_pkg::W_SEMI;
            end
            rcd_pkg::M_NAME: begin
               sa_in.kind = known ? rcd_pkg::SK_CP : rcd_pkg::SK_LIT;
               sa_in.data = named_cp;
               sa_in.warn = known ? rcd_pkg::W_SEMI : rcd_pkg::W_UNKNOWN;
            end
            default: ;
         endcase
         mode_in  = rcd_pkg::M_NORMAL;
         hex_in   = 1'b0;
         code_in  = '0;
         nlen_in  = '0;
         match_in = '0;
      end else begin
         case (mode_ff)
            rcd_pkg::M_AMP: begin
               if (c == rcd_pkg::CH_HASH) begin
                  mode_in = rcd_pkg::M_HASH;
               end else if (item.alnum) begin
                  nwr     = 1'b1;
                  nwr_idx = '0;
                  nlen_in = NW'(1);
                  mode_in = rcd_pkg::M_NAME;
                  for (int i = 0; i < rcd_pkg::NUM_NAMES; i++) begin
                     match_in[i] = (rcd_pkg::name_char(i, '0) == c);
                  end
               end else begin
                  sa_in.kind = rcd_pkg::SK_RAW;
                  sa_in.data = 21'(rcd_pkg::CH_AMP);
                  sa_in.warn = rcd_pkg::W_UNKNOWN;
                  mode_in = rcd_pkg::M_NORMAL;
                  replay  = 1'b1;
               end
            end
            rcd_pkg::M_HASH: begin
               if (c == rcd_pkg::CH_LX || c == rcd_pkg::CH_UX) begin
                  hex_in  = 1'b1;
                  mode_in = (c == rcd_pkg::CH_LX) ? rcd_pkg::M_HEXL : rcd_pkg::M_HEXU;
               end else if (item.dec_ok) begin
                  hex_in  = 1'b0;
                  code_in = 21'(item.dval);
                  mode_in = rcd_pkg::M_DIGITS;
               end else begin
                  sa_in.kind = rcd_pkg::SK_NODIG;
                  sa_in.warn = rcd_pkg::W_NODIG;
                  mode_in = rcd_pkg::M_NORMAL;
                  replay  = 1'b1;
               end
            end
            rcd_pkg::M_HEXL, rcd_pkg::M_HEXU: begin
               if (item.hex_ok) begin
                  code_in = 21'(item.dval);
                  mode_in = rcd_pkg::M_DIGITS;
               end else begin
                  sa_in.kind = rcd_pkg::SK_NODIG;
                  sa_in.warn = rcd_pkg::W_NODIG;
                  sa_in.data = (mode_ff == rcd_pkg::M_HEXL) ? 21'd1 : 21'd2;
                  mode_in = rcd_pkg::M_NORMAL;
                  replay  = 1'b1;
               end
            end
            rcd_pkg::M_DIGITS: begin
               if (hex_ff ? item.hex_ok : item.dec_ok) begin
                  code_in = acc;
               end else begin
                  mode_in    = rcd_pkg::M_NORMAL;
                  sa_in.kind = rcd_pkg::SK_CP;
                  sa_in.data = num_cp;
                  if (c == rcd_pkg::CH_SEMI) begin
                     sa_in.warn = rcd_pkg::W_NONE;
                  end else begin
                     sa_in.warn = rcd_pkg::W_SEMI;
                     replay = 1'b1;
                  end
               end
            end
            rcd_pkg::M_NAME: begin
               mode_in = rcd_pkg::M_NORMAL;
               replay  = 1'b1;
               sa_in.kind = rcd_pkg::SK_LIT;
               sa_in.warn = rcd_pkg::W_UNKNOWN;
               if (item.alnum) begin
                  if (nlen_ff < NW'(NAME_MAX)) begin
                     nwr     = 1'b1;
                     nlen_in = nlen_ff + NW'(1);
                     mode_in = rcd_pkg::M_NAME;
                     replay  = 1'b0;
                     sa_in.kind = rcd_pkg::SK_NONE;
                     for (int i = 0; i < rcd_pkg::NUM_NAMES; i++) begin
                        match_in[i] = match_ff[i] && (rcd_pkg::name_char(i, nlen_ff) == c);
                     end
                  end
               end else if (known) begin
                  sa_in.kind = rcd_pkg::SK_CP;
                  sa_in.data = named_cp;
                  if (c == rcd_pkg::CH_SEMI) begin
                     sa_in.warn = rcd_pkg::W_NONE;
                     replay = 1'b0;
                  end else begin
                     sa_in.warn = rcd_pkg::W_SEMI;
                  end
               end
            end
            default: do_norm = 1'b1;
         endcase
         // plain text handling, also for a byte replayed after a failed reference
         if (do_norm || replay) begin
            mode_in = rcd_pkg::M_NORMAL;
            if (c == rcd_pkg::CH_AMP) begin
               nlen_in = '0;
               code_in = '0;
               hex_in  = 1'b0;
               mode_in = rcd_pkg::M_AMP;
            end else if (c == rcd_pkg::CH_NUL) begin
               nseg.kind = rcd_pkg::SK_CP;
               nseg.data = rcd_pkg::CP_REPL;
               nseg.warn = rcd_pkg::W_NULL;
            end else begin
               nseg.kind = rcd_pkg::SK_RAW;
               nseg.data = 21'(c);
            end
            if (replay) sb_in = nseg;
            else sa_in = nseg;
         end
      end
      la_in   = rcd_pkg::seg_len(sa_in);
      lb      = rcd_pkg::seg_len(sb_in);
      sum_len = la_in + lb;
      tot_in  = (sum_len > (NW+1)'(rcd_pkg::MAX_RESULTS)) ? CW'(rcd_pkg::MAX_RESULTS)
                                                          : CW'(sum_len);
   end

   // byte k of the current item's runs
   always_comb begin
      kk  = (NW+1)'(k_ff);
      cur = (kk < la_ff) ? sa_ff : sb_ff;
      kb  = (kk < la_ff) ? kk : kk - la_ff;
      lit_ch = name_store[IDX_W'(kb - (NW+1)'(1))];
      case (cur.kind)
         rcd_pkg::SK_RAW: ebyte = cur.data[7:0];
         rcd_pkg::SK_CP:  ebyte = rcd_pkg::utf8_byte(cur.data, kb[1:0]);
         rcd_pkg::SK_LIT: ebyte = (kb == '0) ? rcd_pkg::CH_AMP : lit_ch;
         rcd_pkg::SK_NODIG: begin
            case (kb[1:0])
               2'd0: ebyte = rcd_pkg::CH_AMP;
               2'd1: ebyte = rcd_pkg::CH_HASH;
               default: ebyte = cur.data[0] ? rcd_pkg::CH_LX : rcd_pkg::CH_UX;
            endcase
         end
         default: ebyte = 8'h00;
      endcase
      ewarn = cur.warn;
      elast = (k_ff == tot_ff - CW'(1));
   end

   assign slot_free = !oval_ff || rsp_pop;

   // sequencer next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         rcd_pkg::ST_IDLE: if (item_valid && tot_in != '0) st_in = rcd_pkg::ST_EMIT;
         rcd_pkg::ST_EMIT: if (slot_free && elast) st_in = rcd_pkg::ST_IDLE;
         default: st_in = rcd_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      start = 1'b0;
      emit  = 1'b0;
      case (st_ff)
         rcd_pkg::ST_IDLE: start = item_valid;
         rcd_pkg::ST_EMIT: emit  = slot_free;
         default: ;
      endcase
   end

   assign item_take = start;

   always_comb begin
      k_in = start ? '0 : (emit ? k_ff + CW'(1) : k_ff);
      if (emit) oval_in = 1'b1;
      else if (rsp_pop) oval_in = 1'b0;
      else oval_in = oval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= rcd_pkg::ST_IDLE;
         mode_ff  <= rcd_pkg::M_NORMAL;
         hex_ff   <= 1'b0;
         code_ff  <= '0;
         nlen_ff  <= '0;
         match_ff <= '0;
         oval_ff  <= 1'b0;
         k_ff     <= '0;
         tot_ff   <= '0;
      end else begin
         st_ff   <= st_in;
         oval_ff <= oval_in;
         k_ff    <= k_in;
         if (start) begin
            mode_ff  <= mode_in;
            hex_ff   <= hex_in;
            code_ff  <= code_in;
            nlen_ff  <= nlen_in;
            match_ff <= match_in;
            tot_ff   <= tot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
         la_ff <= la_in;
      end
      if (emit) begin
         obyte_ff <= ebyte;
         olast_ff <= elast;
         owarn_ff <= ewarn;
      end
   end

   always_ff @(posedge clock) begin
      if (start && nwr) begin
         name_store[nwr_idx] <= c;
      end
   end

   assign rsp_out_byte  = obyte_ff;
   assign rsp_last      = olast_ff;
   assign rsp_warn_code = owarn_ff;
   assign rsp_empty     = !oval_ff;

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == rcd_pkg::ST_EMIT) |-> (tot_ff != '0 && k_ff < tot_ff))
      else $error("emitting past the run length");
   assert property (@(posedge clock) disable iff (reset)
      nlen_ff <= NW'(NAME_MAX))
      else $error("name length beyond store depth");
   assert property (@(posedge clock) disable iff (reset)
      (emit && elast) |=> (st_ff == rcd_pkg::ST_IDLE && rsp_last && !rsp_empty))
      else $error("final byte did not end the run");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == rcd_pkg::ST_EMIT) |-> !item_take)
      else $error("item taken while emitting");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the HTML character reference decoder: directed table, then random text.
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
      logic [2:0] w;
   } rsp_type;

   typedef struct packed {
      logic [7:0] b;
      logic       f;
   } txt_type;

   typedef struct {
      logic [7:0] b;
      logic       f;
      bit         chk;
      logic [7:0] eb;
      logic [2:0] ew;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_flush = 1'b0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic [2:0] rsp_warn_code;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;

   html_char_reference_decoder dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   localparam logic [15:0] C1_MAP [32] = '{
      16'h20AC, 16'h0, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0, 16'h017D, 16'h0,
      16'h0, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0, 16'h017E, 16'h0178
   };
   localparam int NMAX = rcd_pkg::NAME_MAX_DEF;
   localparam string ALNUM =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

   // decoder state mirror
   rcd_pkg::mode_type mode = rcd_pkg::M_NORMAL;
   bit          hexf = 1'b0;
   int unsigned acc = 0;
   logic [7:0]  nm [NMAX];
   int          nlen = 0;
   rsp_type     run [$];
   rsp_type     utf8_q [$];
   txt_type     stim_q [$];
   int          errors = 0;
   bit          burst = 1'b0;

   function automatic bit is_alnum(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic int digit_val(logic [7:0] c, bit hex);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (hex && c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (hex && c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void put_b(logic [7:0] b, logic [2:0] w);
      rsp_type r;
      r.b = b; r.last = 1'b0; r.w = w;
      if (run.size() < rcd_pkg::MAX_RESULTS) run = {run, r};
   endfunction

   function automatic void put_cp(int unsigned cp, logic [2:0] w);
      if (cp == 0 || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
         put_b(8'hEF, w); put_b(8'hBF, w); put_b(8'hBD, w);
      end else if (cp <= 32'h7F) begin
         put_b(cp[7:0], w);
      end else if (cp <= 32'h7FF) begin
         put_b(8'hC0 | {3'b0, cp[10:6]}, w);
         put_b(8'h80 | {2'b0, cp[5:0]}, w);
      end else if (cp <= 32'hFFFF) begin
         put_b(8'hE0 | {4'b0, cp[15:12]}, w);
         put_b(8'h80 | {2'b0, cp[11:6]}, w);
         put_b(8'h80 | {2'b0, cp[5:0]}, w);
      end else begin
         put_b(8'hF0 | {5'b0, cp[20:18]}, w);
         put_b(8'h80 | {2'b0, cp[17:12]}, w);
         put_b(8'h80 | {2'b0, cp[11:6]}, w);
         put_b(8'h80 | {2'b0, cp[5:0]}, w);
      end
   endfunction

   function automatic void put_numeric(logic [2:0] w);
      int unsigned v;
      v = acc;
      if (v >= 32'h80 && v <= 32'h9F && C1_MAP[v - 32'h80] != 16'h0)
         v = 32'(C1_MAP[v - 32'h80]);
      put_cp(v, w);
   endfunction

   function automatic void put_literal(logic [2:0] w);
      put_b(rcd_pkg::CH_AMP, w);
      for (int i = 0; i < nlen; i++) put_b(nm[i], w);
   endfunction

   function automatic bit put_named(logic [2:0] w);
      bit hit;
      for (int i = 0; i < rcd_pkg::NUM_NAMES; i++) begin
         if (int'(rcd_pkg::NAME_LEN[i]) == nlen) begin
            hit = 1'b1;
            for (int k = 0; k < nlen; k++)
               if (rcd_pkg::NAME_TXT[i][8*(nlen-1-k) +: 8] != nm[k]) hit = 1'b0;
            if (hit) begin
               put_cp(32'(rcd_pkg::NAME_CP[i]), w);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic void put_nodigits();
      put_b(rcd_pkg::CH_AMP, rcd_pkg::W_NODIG); put_b(rcd_pkg::CH_HASH, rcd_pkg::W_NODIG);
      if (mode == rcd_pkg::M_HEXL) put_b(rcd_pkg::CH_LX, rcd_pkg::W_NODIG);
      if (mode == rcd_pkg::M_HEXU) put_b(rcd_pkg::CH_UX, rcd_pkg::W_NODIG);
   endfunction

   // returns 1 when the byte must be replayed as plain text
   function automatic bit decode_byte(logic [7:0] c);
      int d;
      case (mode)
         rcd_pkg::M_AMP: begin
            if (c == rcd_pkg::CH_HASH) begin mode = rcd_pkg::M_HASH; return 0; end
            if (is_alnum(c)) begin nm[0] = c; nlen = 1; mode = rcd_pkg::M_NAME; return 0; end
            put_b(rcd_pkg::CH_AMP, rcd_pkg::W_UNKNOWN); mode = rcd_pkg::M_NORMAL; return 1;
         end
         rcd_pkg::M_HASH: begin
            if (c == rcd_pkg::CH_LX || c == rcd_pkg::CH_UX) begin
               hexf = 1'b1;
               mode = (c == rcd_pkg::CH_LX) ? rcd_pkg::M_HEXL : rcd_pkg::M_HEXU;
               return 0;
            end
            d = digit_val(c, 1'b0);
            if (d >= 0) begin hexf = 1'b0; acc = d; mode = rcd_pkg::M_DIGITS; return 0; end
            put_nodigits(); mode = rcd_pkg::M_NORMAL; return 1;
         end
         rcd_pkg::M_HEXL, rcd_pkg::M_HEXU: begin
            d = digit_val(c, 1'b1);
            if (d >= 0) begin acc = d; mode = rcd_pkg::M_DIGITS; return 0; end
            put_nodigits(); mode = rcd_pkg::M_NORMAL; return 1;
         end
         rcd_pkg::M_DIGITS: begin
            d = digit_val(c, hexf);
            if (d >= 0) begin
               acc = acc * (hexf ? 16 : 10) + d;
               if (acc > rcd_pkg::CP_SAT) acc = 32'(rcd_pkg::CP_SAT);
               return 0;
            end
            mode = rcd_pkg::M_NORMAL;
            if (c == rcd_pkg::CH_SEMI) begin put_numeric(rcd_pkg::W_NONE); return 0; end
            put_numeric(rcd_pkg::W_SEMI); return 1;
         end
         rcd_pkg::M_NAME: begin
            if (is_alnum(c)) begin
               if (nlen < NMAX) begin nm[nlen] = c; nlen++; return 0; end
               put_literal(rcd_pkg::W_UNKNOWN); mode = rcd_pkg::M_NORMAL; return 1;
            end
            mode = rcd_pkg::M_NORMAL;
            if (c == rcd_pkg::CH_SEMI) begin
               if (put_named(rcd_pkg::W_NONE)) return 0;
               put_literal(rcd_pkg::W_UNKNOWN); return 1;
            end
            if (!put_named(rcd_pkg::W_SEMI)) put_literal(rcd_pkg::W_UNKNOWN);
            return 1;
         end
         default: begin
            mode = rcd_pkg::M_NORMAL;
            if (c == rcd_pkg::CH_AMP) begin
               nlen = 0; acc = 0; hexf = 1'b0; mode = rcd_pkg::M_AMP;
            end
            else if (c == rcd_pkg::CH_NUL) put_cp(32'(rcd_pkg::CP_REPL), rcd_pkg::W_NULL);
            else put_b(c, rcd_pkg::W_NONE);
            return 0;
         end
      endcase
   endfunction

   // work out the bytes of one accepted transaction and queue them
   function automatic void predict_utf8(logic [7:0] c, logic f);
      run.delete();
      if (f) begin
         case (mode)
            rcd_pkg::M_AMP: put_b(rcd_pkg::CH_AMP, rcd_pkg::W_NONE);
            rcd_pkg::M_HASH, rcd_pkg::M_HEXL, rcd_pkg::M_HEXU: put_nodigits();
            rcd_pkg::M_DIGITS: put_numeric(rcd_pkg::W_SEMI);
            rcd_pkg::M_NAME: if (!put_named(rcd_pkg::W_SEMI)) put_literal(rcd_pkg::W_UNKNOWN);
            default: ;
         endcase
         mode = rcd_pkg::M_NORMAL; hexf = 1'b0; acc = 0; nlen = 0;
      end else if (decode_byte(c)) begin
         void'(decode_byte(c));
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) utf8_q = {utf8_q, run[i]};
   endfunction

   function automatic void flag(string msg);
      if (errors < 10) $display("%t %s", $realtime, msg);
      errors++;
   endfunction

   task automatic send(logic [7:0] b, logic f);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_in_byte = b;
      req_flush = f;
      do @(posedge clock); while (req_full);
      predict_utf8(b, f);
   endtask

   function automatic void add(logic [7:0] b, logic f = 1'b0);
      txt_type t;
      t.b = b; t.f = f;
      stim_q = {stim_q, t};
   endfunction

   function automatic logic [7:0] any_alnum();
      return ALNUM[$urandom_range(0, 61)];
   endfunction

   function automatic logic [7:0] non_alnum();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_alnum(c));
      return c;
   endfunction

   // close a reference: semicolon, stray byte or end of text
   function automatic void add_end();
      case ($urandom_range(0, 3))
         1: add(non_alnum());
         2: add(8'($urandom), 1'b1);
         default: add(rcd_pkg::CH_SEMI);
      endcase
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add(s[i]);
   endfunction

   function automatic void gen_sequence();
      int n, idx;
      string s;
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(1, 4);
            repeat (n) add(8'($urandom_range(0, 255)));
         end
         2, 3: begin
            idx = $urandom_range(0, rcd_pkg::NUM_NAMES - 1);
            add(rcd_pkg::CH_AMP);
            for (int k = 0; k < int'(rcd_pkg::NAME_LEN[idx]); k++)
               add(rcd_pkg::NAME_TXT[idx][8*(int'(rcd_pkg::NAME_LEN[idx])-1-k) +: 8]);
            add_end();
         end
         4: begin
            case ($urandom_range(0, 3))
               0: s = $sformatf("%0d", $urandom_range(0, 300));
               1: s = $sformatf("%0d", $urandom_range(128, 159));
               2: s = $sformatf("%0d", $urandom_range(0, 1200000));
               default: s = $sformatf("%0d", $urandom_range(0, 99999999));
            endcase
            add_text("&#");
            add_text(s);
            add_end();
         end
         5: begin
            case ($urandom_range(0, 2))
               0: s = $sformatf("%0h", $urandom_range(0, 32'h1FFFFF));
               1: s = $sformatf("%0H", $urandom_range(32'hD7F0, 32'hE010));
               default: s = $sformatf("%0h", $urandom);
            endcase
            add(rcd_pkg::CH_AMP); add(rcd_pkg::CH_HASH);
            add($urandom_range(0, 1) ? rcd_pkg::CH_LX : rcd_pkg::CH_UX);
            foreach (s[i]) add(($urandom_range(0, 1) && s[i] >= "a") ? s[i] - 8'h20 : s[i]);
            add_end();
         end
         6: begin
            n = $urandom_range(0, 18);
            add(rcd_pkg::CH_AMP);
            repeat (n) add(any_alnum());
            add_end();
         end
         7: begin
            add(rcd_pkg::CH_AMP); add(rcd_pkg::CH_HASH);
            case ($urandom_range(0, 2))
               0: add(rcd_pkg::CH_LX);
               1: add(rcd_pkg::CH_UX);
               default: ;
            endcase
            if ($urandom_range(0, 3) == 0) add(8'h00, 1'b1);
            else add(8'("g" + $urandom_range(0, 19)));
         end
         8: add(rcd_pkg::CH_NUL);
         default: add(8'($urandom), 1'b1);
      endcase
   endfunction

   // result side: random pop gaps, compare against the oldest expected byte
   initial begin
      int gap;
      rsp_type e;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = burst ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_pop = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (utf8_q.size() == 0) begin
            flag($sformatf("unexpected transaction byte=%h last=%b warn=%0d",
                           rsp_out_byte, rsp_last, rsp_warn_code));
         end else begin
            e = utf8_q.pop_front();
            if (rsp_out_byte !== e.b || rsp_last !== e.last || rsp_warn_code !== e.w)
               flag($sformatf("mismatch exp byte=%h last=%b warn=%0d got byte=%h last=%b warn=%0d",
                              e.b, e.last, e.w, rsp_out_byte, rsp_last, rsp_warn_code));
         end
         @(negedge clock);
      end
   end

   initial begin
      row_type rows [$];
      row_type r;
      txt_type t;
      int nsent;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows: extremes, named, numeric with C1 remap, no digits,
      // unknown name, flush with a bare ampersand, flush in plain text
      rows = '{
         '{8'h00, 1'b0, 1'b1, 8'hEF, rcd_pkg::W_NULL},
         '{8'hFF, 1'b0, 1'b1, 8'hFF, rcd_pkg::W_NONE},
         '{"&", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"l", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"t", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{";", 1'b0, 1'b1, 8'h3C, rcd_pkg::W_NONE},
         '{"&", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"#", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"1", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"2", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"8", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{";", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"&", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"#", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"x", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"Q", 1'b0, 1'b1, rcd_pkg::CH_AMP, rcd_pkg::W_NODIG},
         '{"&", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"z", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{"z", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{" ", 1'b0, 1'b1, rcd_pkg::CH_AMP, rcd_pkg::W_UNKNOWN},
         '{"&", 1'b0, 1'b0, 8'h00, rcd_pkg::W_NONE},
         '{8'h00, 1'b1, 1'b1, rcd_pkg::CH_AMP, rcd_pkg::W_NONE},
         '{8'hA5, 1'b1, 1'b0, 8'h00, rcd_pkg::W_NONE}
      };
      foreach (rows[i]) begin
         r = rows[i];
         send(r.b, r.f);
         if (r.chk && (run.size() == 0 || run[0].b !== r.eb || run[0].w !== r.ew))
            flag($sformatf("row %0d: table expects byte=%h warn=%0d", i, r.eb, r.ew));
      end

      nsent = 0;
      while (nsent < 200) begin
         if ($urandom_range(0, 15) == 0) burst = ~burst;
         gen_sequence();
         while (stim_q.size() > 0) begin
            t = stim_q.pop_front();
            send(t.b, t.f);
            nsent++;
         end
      end
      @(negedge clock);
      req_push = 1'b0;
      burst = 1'b0;
      while (utf8_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && utf8_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rcd_pkg.sv
hw/rtl/rcd_front.sv
hw/rtl/rcd_back.sv
hw/rtl/html_char_reference_decoder.sv
tb/sv/tb_top.sv
